[hw/rtl/sba_pkg.sv]
// Shared constants, widths and codes of the size-class bin allocator.
`default_nettype none

package sba_pkg;

  localparam int NUM_CLASSES     = 8;
  localparam int MIN_CLASS_BYTES = 32;
  localparam int CHUNK_BYTES     = 65536;
  localparam int NUM_CHUNKS      = 16;
  localparam int HEADER_BYTES    = 8;

  // Fixed payload widths
  localparam int ADDR_W   = 20;
  localparam int SIZE_W   = 32;
  localparam int CLASS_W  = 3;
  localparam int STATUS_W = 2;

  // Class index and owner code (owner value NUM_CLASSES marks a free chunk)
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int OWNER_W = $clog2(NUM_CLASSES + 1);

  // Chunk geometry (chunk size is a power of two)
  localparam int CHUNK_SH    = $clog2(CHUNK_BYTES);
  localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
  localparam int USED_W      = $clog2(NUM_CHUNKS + 1);
  localparam int INIT_CHUNKS = (NUM_CLASSES < NUM_CHUNKS) ? NUM_CLASSES : NUM_CHUNKS;

  // Link store: one entry per minimum cell of the address space
  localparam int LINK_SH    = $clog2(MIN_CLASS_BYTES);
  localparam int LINK_AW    = ADDR_W - LINK_SH;
  localparam int LINK_DEPTH = 1 << LINK_AW;
  localparam int LINK_W     = ADDR_W + 1;

  // Carving counters and strides
  localparam int CELL_W   = $clog2((CHUNK_BYTES - 1) / (MIN_CLASS_BYTES + HEADER_BYTES) + 1);
  localparam int STRIDE_W = $clog2((MIN_CLASS_BYTES << (NUM_CLASSES - 1)) + HEADER_BYTES + 1);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_CHUNK  = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/sba_req_if.sv]
// Request and result channel interfaces of the size-class bin allocator.
`default_nettype none

interface sba_req_if;
  import sba_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] block_addr;

  modport source (output valid, output req_type, output request_size, output block_addr,
                  input ready);
  modport sink   (input valid, input req_type, input request_size, input block_addr,
                  output ready);
endinterface

interface sba_rsp_if;
  import sba_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   granted_addr;
  logic [CLASS_W-1:0]  size_class;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_addr, output size_class, output status,
                  input ready);
  modport sink   (input valid, input granted_addr, input size_class, input status,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/size_class_bin_allocator_unit.sv]
// Top level of the size-class bin allocator: request decode, class tables and link store.
// Sequence: S_IDLE takes a request; S_EXEC registers free, carve and status results, a pop
//   reads the link store there and emits from S_POP, and the first allocation and a refill
//   each rerun S_EXEC. Requests are taken only in S_IDLE, and sink stalls hold S_EXEC and S_POP.
// Reset: clears control, class counters and chunk owners at once; the link store is not
//   cleared, since a pop only follows entries that an earlier free wrote.
`default_nettype none

module size_class_bin_allocator_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sba_req_if.sink         in_chan,
  sba_rsp_if.source       out_chan
);
  import sba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  // ---------------------------------------------------------------------------
  // Constant tables: stride, cells per chunk and size limit of each class
  // ---------------------------------------------------------------------------
  logic [STRIDE_W-1:0] stride_tab [NUM_CLASSES];
  logic [CELL_W-1:0]   cells_tab  [NUM_CLASSES];
  logic [SIZE_W:0]     limit_tab  [NUM_CLASSES];

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_tab
    localparam int Stride = (MIN_CLASS_BYTES << g) + HEADER_BYTES;
    localparam int Cells  = (CHUNK_BYTES - 1) / Stride;
    localparam int Limit  = MIN_CLASS_BYTES << g;
    assign stride_tab[g] = STRIDE_W'(Stride);
    assign cells_tab[g]  = CELL_W'(Cells);
    assign limit_tab[g]  = (SIZE_W + 1)'(Limit);
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic               req_type_r;
  logic [SIZE_W-1:0]  size_r;
  logic [ADDR_W-1:0]  baddr_r;
  logic               initialized_r;
  logic [USED_W-1:0]  chunks_used_r;

  logic [ADDR_W-1:0]      fh_r          [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] fhv_r;
  logic [CHUNK_IDX_W-1:0] carve_chunk_r [NUM_CLASSES];
  logic [CELL_W-1:0]      carve_rem_r   [NUM_CLASSES];
  logic [OWNER_W-1:0]     owner_r       [NUM_CHUNKS];

  // Link store: bit ADDR_W is next-valid, the rest the next freed address
  logic [LINK_W-1:0] link_mem [LINK_DEPTH];
  logic [LINK_W-1:0] link_rdata_r;

  // Result slot
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [CLASS_W-1:0]  out_cls_r;
  logic [STATUS_W-1:0] out_status_r;

  // ---------------------------------------------------------------------------
  // Decode of the held request
  // ---------------------------------------------------------------------------
  logic                      alloc_hit;
  logic [CLS_W-1:0]          alloc_cls;
  logic [ADDR_W-CHUNK_SH-1:0] chunk_num;
  logic [CHUNK_IDX_W-1:0]    chunk_idx;
  logic [OWNER_W-1:0]        owner;
  logic                      owned;
  logic                      is_free;
  logic [CLS_W-1:0]          cls;

  // Find the smallest class that fits; a size above every limit is oversize
  always_comb begin
    alloc_hit = 1'b0;
    alloc_cls = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if ({1'b0, size_r} <= limit_tab[i]) begin
        alloc_hit = 1'b1;
        alloc_cls = CLS_W'(i);
      end
    end
  end

  assign is_free   = (req_type_r == REQ_FREE);
  assign chunk_num = baddr_r[ADDR_W-1:CHUNK_SH];
  assign chunk_idx = CHUNK_IDX_W'(chunk_num);
  assign owner     = owner_r[chunk_idx];
  assign owned     = (int'(chunk_num) < NUM_CHUNKS) && (int'(owner) < NUM_CLASSES);
  assign cls       = is_free ? CLS_W'(owner) : alloc_cls;

  // Carve address: chunk base + (remaining-1) * stride + header
  logic [CELL_W-1:0]          rem_dec;
  logic [CELL_W+STRIDE_W-1:0] carve_prod;
  logic [ADDR_W-1:0]          carve_addr;

  assign rem_dec    = carve_rem_r[cls] - CELL_W'(1);
  assign carve_prod = CELL_W'(rem_dec) * STRIDE_W'(stride_tab[cls]);
  assign carve_addr = ADDR_W'({carve_chunk_r[cls], {CHUNK_SH{1'b0}}})
                    + ADDR_W'(carve_prod) + ADDR_W'(HEADER_BYTES);

  // ---------------------------------------------------------------------------
  // Sequencer decisions
  // ---------------------------------------------------------------------------
  logic                slot_free;
  logic                emit;
  logic [ADDR_W-1:0]   emit_addr;
  logic [CLS_W-1:0]    emit_cls;
  status_t             emit_status;
  logic                do_push, do_init, do_refill, do_read, do_carve, do_pop;

  assign slot_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt   = state_r;
    emit        = 1'b0;
    emit_addr   = '0;
    emit_cls    = '0;
    emit_status = ST_OK;
    do_push     = 1'b0;
    do_init     = 1'b0;
    do_refill   = 1'b0;
    do_read     = 1'b0;
    do_carve    = 1'b0;
    do_pop      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_free) begin
          // Free: drop addresses outside owned chunks, push the rest as given
          emit_cls    = owned ? cls : '0;
          emit_status = owned ? ST_OK : ST_BAD_ADDR;
          if (slot_free) begin
            emit      = 1'b1;
            do_push   = owned;
            state_nxt = S_IDLE;
          end
        end else if (!alloc_hit) begin
          emit_status = ST_TOO_LARGE;
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!initialized_r) begin
          do_init = 1'b1;
        end else if (fhv_r[cls]) begin
          do_read   = 1'b1;
          state_nxt = S_POP;
        end else if (carve_rem_r[cls] == '0) begin
          if (int'(chunks_used_r) >= NUM_CHUNKS || cells_tab[cls] == '0) begin
            emit_cls    = cls;
            emit_status = ST_NO_CHUNK;
            if (slot_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            do_refill = 1'b1;
          end
        end else begin
          emit_addr = carve_addr;
          emit_cls  = cls;
          if (slot_free) begin
            emit      = 1'b1;
            do_carve  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_POP: begin
        // Hand out the stack head; the link entry read in S_EXEC becomes the new head
        emit_addr = fh_r[cls];
        emit_cls  = cls;
        if (slot_free) begin
          emit      = 1'b1;
          do_pop    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_chan.ready = (state_r == S_IDLE);

  // ---------------------------------------------------------------------------
  // Control and class tables
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      initialized_r <= 1'b0;
      chunks_used_r <= '0;
      fhv_r         <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        carve_chunk_r[i] <= '0;
        carve_rem_r[i]   <= '0;
      end
      for (int c = 0; c < NUM_CHUNKS; c++) begin
        owner_r[c] <= OWNER_W'(NUM_CLASSES);
      end
    end else begin
      state_r <= state_nxt;

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      // First allocation: give chunk i to class i and carve it whole
      if (do_init) begin
        initialized_r <= 1'b1;
        chunks_used_r <= USED_W'(INIT_CHUNKS);
        for (int i = 0; i < INIT_CHUNKS; i++) begin
          carve_chunk_r[i] <= CHUNK_IDX_W'(i);
          carve_rem_r[i]   <= cells_tab[i];
          owner_r[i]       <= OWNER_W'(i);
        end
      end

      // Refill: take the next unused chunk for an empty class
      if (do_refill) begin
        carve_chunk_r[cls] <= CHUNK_IDX_W'(chunks_used_r);
        carve_rem_r[cls]   <= cells_tab[cls];
        owner_r[CHUNK_IDX_W'(chunks_used_r)] <= OWNER_W'(cls);
        chunks_used_r      <= chunks_used_r + USED_W'(1);
      end

      if (do_carve) begin
        carve_rem_r[cls] <= rem_dec;
      end

      if (do_push) begin
        fhv_r[cls] <= 1'b1;
      end

      if (do_pop) begin
        fhv_r[cls] <= link_rdata_r[ADDR_W];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      req_type_r <= in_chan.req_type;
      size_r     <= in_chan.request_size;
      baddr_r    <= in_chan.block_addr;
    end
    if (emit) begin
      out_addr_r   <= emit_addr;
      out_cls_r    <= CLASS_W'(emit_cls);
      out_status_r <= emit_status;
    end
    if (do_push) begin
      fh_r[cls] <= baddr_r;
    end
    if (do_pop) begin
      fh_r[cls] <= link_rdata_r[ADDR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Link store: a push writes the old head under the freed cell, a pop reads it back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (do_push) begin
      link_mem[baddr_r[ADDR_W-1:LINK_SH]] <= {fhv_r[cls], fh_r[cls]};
    end
    if (do_read) begin
      link_rdata_r <= link_mem[fh_r[cls][ADDR_W-1:LINK_SH]];
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.granted_addr = out_addr_r;
  assign out_chan.size_class   = out_cls_r;
  assign out_chan.status       = out_status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // Never hand out more chunks than the heap holds
  a_chunks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(chunks_used_r) <= NUM_CHUNKS)
    else $error("chunk count beyond heap");

  // A pop only starts on a class whose freed stack is non-empty
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> fhv_r[cls])
    else $error("pop from empty freed stack");

  // Any result that is not ok carries a zero address
  a_status_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_addr_r == '0))
    else $error("nonzero address on failed request");

  // Owner entry of chunk 0 only changes on init or refill
  a_owner_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!do_init && !do_refill) |=> (owner_r[0] == $past(owner_r[0])))
    else $error("chunk owner changed without refill");
`endif

endmodule

`default_nettype wire
